FILE: sv/cv_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the channel vocoder
// no dependencies

package cv_pkg;

    localparam int NUM_BANDS_DEF = 16;
    localparam int MAX_NOTES_DEF = 8;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 40;
    localparam int WET_W  = 64;

    // item modes
    localparam logic [2:0] MODE_SAMPLE   = 3'd0;
    localparam logic [2:0] MODE_NOTE_ON  = 3'd1;
    localparam logic [2:0] MODE_NOTE_OFF = 3'd2;
    localparam logic [2:0] MODE_ALL_OFF  = 3'd3;
    localparam logic [2:0] MODE_PANIC    = 3'd4;
    localparam logic [2:0] MODE_LOAD     = 3'd5;

    // register indexes
    localparam logic [2:0] CFG_CARRIER_MODE = 3'd0;
    localparam logic [2:0] CFG_FIXED_NOTE   = 3'd1;
    localparam logic [2:0] CFG_ATTACK       = 3'd2;
    localparam logic [2:0] CFG_RELEASE      = 3'd3;
    localparam logic [2:0] CFG_GAIN         = 3'd4;
    localparam logic [2:0] CFG_NOISE_MIX    = 3'd5;
    localparam logic [2:0] CFG_INV_RATE     = 3'd6;

    localparam logic [6:0]  FIXED_NOTE_RST = 7'd60;
    localparam logic [23:0] ATTACK_RST     = 24'd15728640;
    localparam logic [23:0] RELEASE_RST    = 24'd16609443;
    localparam logic [23:0] GAIN_RST       = 24'd8388608;
    localparam logic [31:0] INV_RATE_RST   = 32'd89478;

    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] SEED_RST   = 32'h12345678;
    localparam logic [16:0] MIX_FULL   = 17'd65536;
    localparam logic [23:0] MAG_MAX    = 24'hFFFFFF;
    localparam logic [24:0] ENV_ONE    = 25'h1000000;

    typedef struct packed {
        logic signed [31:0] b0;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } t_coef;

    typedef struct packed {
        logic signed [23:0] ax1;
        logic signed [23:0] ax2;
        logic signed [31:0] ay1;
        logic signed [31:0] ay2;
        logic signed [23:0] sx1;
        logic signed [23:0] sx2;
        logic signed [31:0] sy1;
        logic signed [31:0] sy2;
        logic        [23:0] env;
    } t_band_st;

    // top octave note frequencies, q16.16
    function automatic logic [29:0] top_octave(input logic [3:0] k);
        logic [29:0] f;
        case (k)
            4'd0:    f = 30'd548668578;
            4'd1:    f = 30'd581294109;
            4'd2:    f = 30'd615859655;
            4'd3:    f = 30'd652480576;
            4'd4:    f = 30'd691279090;
            4'd5:    f = 30'd732384684;
            4'd6:    f = 30'd775934544;
            4'd7:    f = 30'd822074013;
            4'd8:    f = 30'd870957077;
            4'd9:    f = 30'd922746880;
            4'd10:   f = 30'd977616265;
            4'd11:   f = 30'd1035748353;
            default: f = 30'd0;
        endcase
        return f;
    endfunction

    // round half up after a right shift by 28
    function automatic logic signed [ACC_W-1:0] rnd28(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = (v + (PROD_W'(1) <<< 27)) >>> 28;
        return t[ACC_W-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(32'sh7FFFFFFF))
            r = 32'sh7FFFFFFF;
        else if (v < -(ACC_W'(1) <<< 31))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: sv/cv_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram with registered read
// no dependencies

module cv_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: sv/cv_mul.sv
`timescale 1ns / 1ps
// shared signed multiplier with registered product
// depends on cv_pkg for the default width

module cv_mul #(
    parameter int W = cv_pkg::MUL_W
) (
    input  logic                    i_clk,
    input  logic signed [W-1:0]     i_a,
    input  logic signed [W-1:0]     i_b,
    output logic signed [2*W-1:0]   o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

FILE: sv/cv_div.sv
`timescale 1ns / 1ps
// bit serial signed by unsigned divider, quotient truncated toward zero
// no dependencies

module cv_div #(
    parameter int DW = 28,
    parameter int VW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_dividend,
    input  logic [VW-1:0]        i_divisor,
    output logic                 o_done,
    output logic signed [DW-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_mag;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_den;
    logic             r_neg;
    logic [VW:0]      w_trial;
    logic [VW:0]      w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_mag[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_quotient = r_neg ? -signed'(r_mag) : signed'(r_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
                r_mag  <= i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
                r_neg  <= i_dividend[DW-1];
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_mag <= {r_mag[DW-2:0], w_ge};
                r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: sv/channel_vocoder.sv
`timescale 1ns / 1ps
// channel vocoder top level: sequencer around a shared multiplier and band rams
// depends on cv_pkg, cv_ram, cv_mul, cv_div
//
// usage
//   input channel (i_valid / o_ready): one beat per item; mode selects sample,
//   note on, note off, all notes off, panic or coefficient load
//   output channel (o_valid / i_ready): one beat of o_wet_sample per sample item
//   config channel (i_cfg_valid / o_cfg_ready): always ready, written while idle
// timing
//   control items finish in the accept cycle; a coefficient load too
//   all notes off and panic run a clearing pass over the band state
//   a sample item runs the carrier oscillators and noise mix, the band loop
//   and the output scaling in turn, all through the single shared multiplier
//   one item is in work at a time; o_ready is high only when the sequencer idles
// reset
//   synchronous, active low; the band state ram is zeroed by a clearing pass
//   before the first item is taken
// stall
//   a finished result waits in the output register; a new item is accepted
//   meanwhile, and a second result waits in the sequencer until the first leaves

module channel_vocoder #(
    parameter int NUM_BANDS = cv_pkg::NUM_BANDS_DEF,
    parameter int MAX_NOTES = cv_pkg::MAX_NOTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic signed [23:0] i_left_sample,
    input  logic signed [23:0] i_right_sample,
    input  logic [6:0]  i_note,
    input  logic [3:0]  i_band_index,
    input  logic signed [31:0] i_coef_b0,
    input  logic signed [31:0] i_coef_a1,
    input  logic signed [31:0] i_coef_a2,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [23:0] o_wet_sample,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import cv_pkg::*;

    localparam int BW    = $clog2(NUM_BANDS);
    localparam int CW    = $clog2(MAX_NOTES + 1);
    localparam int NIW   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int SUM_W = 24 + CW;
    localparam int ST_W  = $bits(t_band_st);
    localparam int CF_W  = $bits(t_coef);

    typedef enum logic [5:0] {
        S_CLR_RD, S_CLR_WR, S_IDLE,
        S_OSC_M, S_OSC_A, S_DIV_GO, S_DIV_WAIT,
        S_NZ_M, S_NZ_A, S_MX1, S_MX2, S_MX3,
        S_B_RD, S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8, S_B9, S_B10,
        S_FIN0, S_FIN1, S_FIN2, S_FIN3, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic        r_carrier_mode;
    logic [6:0]  r_fixed_note;
    logic [23:0] r_attack;
    logic [23:0] r_release;
    logic [23:0] r_gain;
    logic [16:0] r_noise_mix;
    logic [31:0] r_inv_rate;

    // voices
    logic [6:0]  r_notes [MAX_NOTES];
    logic [23:0] r_phase [MAX_NOTES];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_osc_n;
    logic [5:0]  r_shift;
    logic signed [SUM_W-1:0] r_saw_sum;
    logic signed [23:0] r_saw;
    logic [31:0] r_seed;
    logic signed [23:0] r_nz;
    logic signed [PROD_W-1:0] r_acc_m;
    logic signed [23:0] r_car;
    logic signed [23:0] r_modv;

    // band loop
    logic [BW-1:0] r_band;
    logic signed [ACC_W-1:0] r_acc_a;
    logic signed [ACC_W-1:0] r_acc_s;
    logic signed [31:0] r_ya;
    logic signed [31:0] r_ys;
    logic [23:0] r_mag;
    logic [23:0] r_c;
    logic [48:0] r_acc_e;
    logic [23:0] r_env_new;
    logic signed [WET_W-1:0] r_wet;
    logic signed [40:0] r_w;
    logic signed [PROD_W-1:0] r_acc_f;
    logic signed [23:0] r_y;
    logic r_clr_all;
    logic r_clr_env;
    logic r_out_valid;
    logic signed [23:0] r_out_sample;

    // shared multiplier
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_p;

    // rams
    logic            w_cf_we;
    logic [BW-1:0]   w_cf_waddr;
    logic [CF_W-1:0] w_cf_q;
    logic [ST_W-1:0] w_st_q;
    logic            w_st_we;
    logic            w_st_re;
    t_band_st        w_st_wd;
    t_coef           cf;
    t_band_st        st;
    logic [31:0]     w_bi_ext;

    // divider
    logic w_div_start;
    logic w_div_done;
    logic signed [SUM_W-1:0] w_div_q;

    // combinational helpers
    logic [16:0]  w_mixc;
    logic [CW-1:0] w_count_s;
    logic         w_dup;
    logic         w_off_hit;
    logic [CW-1:0] w_off_idx;
    logic [6:0]   w_note;
    logic [12:0]  w_nq;
    logic [3:0]   w_oct;
    logic [6:0]   w_rem;
    logic [63:0]  w_inc;
    logic [23:0]  w_ph;
    logic signed [23:0] w_saw_v;
    logic signed [31:0] w_ya;
    logic [32:0]  w_abs;
    logic [49:0]  w_esum;
    logic signed [WET_W-1:0] w_wr;
    logic signed [67:0] w_fin;
    logic [31:0]  w_seed_n;
    logic signed [PROD_W-1:0] w_car_t;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_wet_sample = r_out_sample;
    assign o_cfg_ready  = 1'b1;

    assign cf = w_cf_q;
    assign st = w_st_q;

    cv_mul #(.W(MUL_W)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    assign w_bi_ext   = 32'(i_band_index);
    assign w_cf_waddr = w_bi_ext[BW-1:0];
    assign w_cf_we    = o_ready && i_valid && (i_mode == MODE_LOAD)
                        && (w_bi_ext < 32'(NUM_BANDS));

    cv_ram #(.W(CF_W), .D(NUM_BANDS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_cf_we),
        .i_waddr (w_cf_waddr),
        .i_wdata ({i_coef_b0, i_coef_a1, i_coef_a2}),
        .i_re    (r_state == S_B_RD),
        .i_raddr (r_band),
        .o_rdata (w_cf_q)
    );

    assign w_st_we = (r_state == S_CLR_WR) || (r_state == S_B10);
    assign w_st_re = (r_state == S_CLR_RD) || (r_state == S_B_RD);

    // write data: band update or clearing pass
    always_comb begin
        if (r_state == S_B10) begin
            w_st_wd.ax1 = r_modv;
            w_st_wd.ax2 = st.ax1;
            w_st_wd.ay1 = r_ya;
            w_st_wd.ay2 = st.ay1;
            w_st_wd.sx1 = r_car;
            w_st_wd.sx2 = st.sx1;
            w_st_wd.sy1 = r_ys;
            w_st_wd.sy2 = st.sy1;
            w_st_wd.env = r_env_new;
        end else begin
            w_st_wd     = '0;
            w_st_wd.ax1 = r_clr_all ? '0 : st.ax1;
            w_st_wd.ax2 = r_clr_all ? '0 : st.ax2;
            w_st_wd.ay1 = r_clr_all ? '0 : st.ay1;
            w_st_wd.ay2 = r_clr_all ? '0 : st.ay2;
            w_st_wd.env = r_clr_env ? '0 : st.env;
        end
    end

    cv_ram #(.W(ST_W), .D(NUM_BANDS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (r_band),
        .i_wdata (w_st_wd),
        .i_re    (w_st_re),
        .i_raddr (r_band),
        .o_rdata (w_st_q)
    );

    assign w_div_start = (r_state == S_DIV_GO);

    cv_div #(.DW(SUM_W), .VW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_saw_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // note list lookups
    always_comb begin
        w_dup     = 1'b0;
        w_off_hit = 1'b0;
        w_off_idx = '0;
        for (int j = MAX_NOTES - 1; j >= 0; j--) begin
            if (CW'(j) < r_count && r_notes[j] == i_note) begin
                w_dup     = 1'b1;
                w_off_hit = 1'b1;
                w_off_idx = CW'(j);
            end
        end
    end

    assign w_mixc    = (r_noise_mix > MIX_FULL) ? MIX_FULL : r_noise_mix;
    assign w_count_s = (!r_carrier_mode && r_count == '0) ? CW'(1) : r_count;

    // oscillator increment: octave by multiply by reciprocal of twelve
    assign w_note  = r_notes[r_osc_n[NIW-1:0]];
    assign w_nq    = 13'(w_note) * 13'd43;
    assign w_oct   = w_nq[12:9];
    assign w_rem   = w_note - 7'(w_oct) * 7'd12;
    assign w_inc   = (w_p[63:0] + (64'd1 << (r_shift - 6'd1))) >> r_shift;
    assign w_ph    = r_phase[r_osc_n[NIW-1:0]] + w_inc[23:0];
    assign w_saw_v = {~w_ph[23], w_ph[22:0]};

    assign w_seed_n = w_p[31:0] + LCG_ADD;
    assign w_car_t  = (r_acc_m + w_p + PROD_W'(32768)) >>> 16;

    assign w_ya   = sat32(r_acc_a);
    assign w_abs  = w_ya[31] ? -33'(w_ya) : 33'(w_ya);
    assign w_esum = 50'(r_acc_e) + 50'(w_p[48:0]) + 50'(24'h800000);
    assign w_wr   = (r_wet + (WET_W'(1) <<< 22)) >>> 23;
    assign w_fin  = ((68'(r_acc_f) <<< 16) + 68'(w_p) + (68'sd1 <<< 21)) >>> 22;

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_OSC_M: begin
                w_mul_a = MUL_W'(top_octave(w_rem[3:0]));
                w_mul_b = MUL_W'(r_inv_rate);
            end
            S_NZ_M: begin
                w_mul_a = MUL_W'(r_seed);
                w_mul_b = MUL_W'(LCG_MUL);
            end
            S_MX1: begin
                w_mul_a = MUL_W'(r_saw);
                w_mul_b = MUL_W'(MIX_FULL - w_mixc);
            end
            S_MX2: begin
                w_mul_a = MUL_W'(r_nz);
                w_mul_b = MUL_W'(w_mixc);
            end
            S_B0: begin
                w_mul_a = MUL_W'(cf.b0);
                w_mul_b = MUL_W'(r_modv) - MUL_W'(st.ax2);
            end
            S_B1: begin
                w_mul_a = MUL_W'(cf.a1);
                w_mul_b = MUL_W'(st.ay1);
            end
            S_B2: begin
                w_mul_a = MUL_W'(cf.a2);
                w_mul_b = MUL_W'(st.ay2);
            end
            S_B3: begin
                w_mul_a = MUL_W'(cf.b0);
                w_mul_b = MUL_W'(r_car) - MUL_W'(st.sx2);
            end
            S_B4: begin
                w_mul_a = MUL_W'(cf.a1);
                w_mul_b = MUL_W'(st.sy1);
            end
            S_B5: begin
                w_mul_a = MUL_W'(cf.a2);
                w_mul_b = MUL_W'(st.sy2);
            end
            S_B6: begin
                w_mul_a = MUL_W'(r_c);
                w_mul_b = MUL_W'(st.env);
            end
            S_B7: begin
                w_mul_a = MUL_W'(ENV_ONE - 25'(r_c));
                w_mul_b = MUL_W'(r_mag);
            end
            S_B9: begin
                w_mul_a = MUL_W'(r_ys);
                w_mul_b = MUL_W'(r_env_new);
            end
            S_FIN1: begin
                w_mul_a = MUL_W'(signed'(r_w[40:16]));
                w_mul_b = MUL_W'(r_gain);
            end
            S_FIN2: begin
                w_mul_a = MUL_W'(r_w[15:0]);
                w_mul_b = MUL_W'(r_gain);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR_RD;
            r_band         <= '0;
            r_clr_all      <= 1'b1;
            r_clr_env      <= 1'b1;
            r_out_valid    <= 1'b0;
            r_count        <= '0;
            r_seed         <= SEED_RST;
            r_carrier_mode <= 1'b0;
            r_fixed_note   <= FIXED_NOTE_RST;
            r_attack       <= ATTACK_RST;
            r_release      <= RELEASE_RST;
            r_gain         <= GAIN_RST;
            r_noise_mix    <= '0;
            r_inv_rate     <= INV_RATE_RST;
            for (int j = 0; j < MAX_NOTES; j++) begin
                r_notes[j] <= '0;
                r_phase[j] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CARRIER_MODE: r_carrier_mode <= i_cfg_data[0];
                    CFG_FIXED_NOTE:   r_fixed_note   <= i_cfg_data[6:0];
                    CFG_ATTACK:       r_attack       <= i_cfg_data[23:0];
                    CFG_RELEASE:      r_release      <= i_cfg_data[23:0];
                    CFG_GAIN:         r_gain         <= i_cfg_data[23:0];
                    CFG_NOISE_MIX:    r_noise_mix    <= i_cfg_data[16:0];
                    CFG_INV_RATE:     r_inv_rate     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // in S_OUT the result register is refilled in the same cycle instead
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                // clearing pass over the band state
                S_CLR_RD: r_state <= S_CLR_WR;
                S_CLR_WR: begin
                    if (r_band == BW'(NUM_BANDS - 1)) begin
                        r_band  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_band  <= r_band + 1'b1;
                        r_state <= S_CLR_RD;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        unique case (i_mode) inside
                            MODE_SAMPLE: begin
                                r_modv <= 24'((25'(i_left_sample) + 25'(i_right_sample)) >>> 1);
                                if (!r_carrier_mode && r_count == '0) begin
                                    r_notes[0] <= r_fixed_note;
                                    r_count    <= CW'(1);
                                end
                                r_osc_n   <= '0;
                                r_saw_sum <= '0;
                                r_saw     <= '0;
                                r_wet     <= '0;
                                r_band    <= '0;
                                r_state   <= (w_count_s != '0) ? S_OSC_M : S_NZ_M;
                            end
                            MODE_NOTE_ON: begin
                                if (r_carrier_mode && !w_dup && r_count < CW'(MAX_NOTES)) begin
                                    r_notes[r_count[NIW-1:0]] <= i_note;
                                    r_phase[r_count[NIW-1:0]] <= '0;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            MODE_NOTE_OFF: begin
                                if (w_off_hit) begin
                                    // remove the first match, shift the rest down
                                    for (int j = 0; j < MAX_NOTES - 1; j++) begin
                                        if (CW'(j) >= w_off_idx && CW'(j + 1) < r_count) begin
                                            r_notes[j] <= r_notes[j+1];
                                            r_phase[j] <= r_phase[j+1];
                                        end
                                    end
                                    r_count <= r_count - 1'b1;
                                end
                            end
                            MODE_ALL_OFF, MODE_PANIC: begin
                                r_count   <= '0;
                                r_clr_all <= 1'b0;
                                r_clr_env <= (i_mode == MODE_PANIC);
                                r_band    <= '0;
                                r_state   <= S_CLR_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // oscillators, a multiply state and an accumulate state per voice
                S_OSC_M: begin
                    r_shift <= 6'd34 - 6'(w_oct);
                    r_state <= S_OSC_A;
                end
                S_OSC_A: begin
                    r_phase[r_osc_n[NIW-1:0]] <= w_ph;
                    r_saw_sum <= r_saw_sum + SUM_W'(w_saw_v);
                    r_osc_n   <= r_osc_n + 1'b1;
                    r_state   <= (r_osc_n + 1'b1 == r_count) ? S_DIV_GO : S_OSC_M;
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_saw   <= w_div_q[23:0];
                        r_state <= S_NZ_M;
                    end
                end
                // noise and carrier mix
                S_NZ_M: r_state <= S_NZ_A;
                S_NZ_A: begin
                    r_seed  <= w_seed_n;
                    r_nz    <= {~w_seed_n[31], w_seed_n[30:8]};
                    r_state <= S_MX1;
                end
                S_MX1: r_state <= S_MX2;
                S_MX2: begin
                    r_acc_m <= w_p;
                    r_state <= S_MX3;
                end
                S_MX3: begin
                    r_car   <= w_car_t[23:0];
                    r_state <= S_B_RD;
                end
                // band loop
                S_B_RD: r_state <= S_B0;
                S_B0:   r_state <= S_B1;
                S_B1: begin
                    r_acc_a <= rnd28(w_p);
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_acc_a <= r_acc_a - rnd28(w_p);
                    r_state <= S_B3;
                end
                S_B3: begin
                    r_acc_a <= r_acc_a - rnd28(w_p);
                    r_state <= S_B4;
                end
                S_B4: begin
                    r_ya    <= w_ya;
                    r_mag   <= (w_abs > 33'(MAG_MAX)) ? MAG_MAX : w_abs[23:0];
                    r_acc_s <= rnd28(w_p);
                    r_state <= S_B5;
                end
                S_B5: begin
                    r_c     <= (r_mag > st.env) ? r_attack : r_release;
                    r_acc_s <= r_acc_s - rnd28(w_p);
                    r_state <= S_B6;
                end
                S_B6: begin
                    r_acc_s <= r_acc_s - rnd28(w_p);
                    r_state <= S_B7;
                end
                S_B7: begin
                    r_acc_e <= w_p[48:0];
                    r_ys    <= sat32(r_acc_s);
                    r_state <= S_B8;
                end
                S_B8: begin
                    r_env_new <= w_esum[47:24];
                    r_state   <= S_B9;
                end
                S_B9: r_state <= S_B10;
                S_B10: begin
                    r_wet <= r_wet + WET_W'(w_p);
                    if (r_band == BW'(NUM_BANDS - 1)) begin
                        r_band  <= '0;
                        r_state <= S_FIN0;
                    end else begin
                        r_band  <= r_band + 1'b1;
                        r_state <= S_B_RD;
                    end
                end
                // gain in two partial products, then saturate
                S_FIN0: begin
                    r_w     <= w_wr[40:0];
                    r_state <= S_FIN1;
                end
                S_FIN1: r_state <= S_FIN2;
                S_FIN2: begin
                    r_acc_f <= w_p;
                    r_state <= S_FIN3;
                end
                S_FIN3: begin
                    if (w_fin > 68'sd8388607)
                        r_y <= 24'sh7FFFFF;
                    else if (w_fin < -68'sd8388608)
                        r_y <= 24'sh800000;
                    else
                        r_y <= w_fin[23:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_y;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for channel_vocoder: queued items drive the input side, results are
// checked against an in-bench bit-accurate prediction of the band filters and carrier
// depends on cv_pkg and channel_vocoder

module tb_top;
    import cv_pkg::*;

    localparam int NB         = 16;
    localparam int NN         = 8;
    localparam int CYC_LIMIT  = 3000000;
    localparam int DRAIN_WAIT = 300;   // outlasts a full sample item
    localparam int LONG_HOLD  = 3000;

    typedef struct {
        logic [2:0]         mode;
        logic signed [23:0] l;
        logic signed [23:0] r;
        logic [6:0]         note;
        logic [3:0]         band;
        logic signed [31:0] b0;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } t_vc_item;

    // top octave note frequencies, q16.16
    localparam longint unsigned OCT_HZ [12] = '{
        548668578, 581294109, 615859655, 652480576, 691279090, 732384684,
        775934544, 822074013, 870957077, 922746880, 977616265, 1035748353};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_mode = '0;
    logic signed [23:0] i_left_sample = '0;
    logic signed [23:0] i_right_sample = '0;
    logic [6:0]         i_note = '0;
    logic [3:0]         i_band_index = '0;
    logic signed [31:0] i_coef_b0 = '0;
    logic signed [31:0] i_coef_a1 = '0;
    logic signed [31:0] i_coef_a2 = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [23:0] o_wet_sample;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    channel_vocoder dut (.*);

    // clock, 12 ns period
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predicted vocoder state and settings
    // ---------------------------------------------------------------
    logic        car_midi;
    logic [6:0]  fix_note;
    logic [23:0] atk, rel, gain;
    logic [16:0] nmix;
    logic [31:0] inv_rate;
    int          bq_b0 [NB];
    int          bq_a1 [NB];
    int          bq_a2 [NB];
    int          ana_hist [NB*4];
    int          syn_hist [NB*4];
    int          env_lvl [NB];
    logic [6:0]  held [NN];
    logic [23:0] phase [NN];
    int          n_held;
    logic [31:0] lcg;

    t_vc_item           item_q [$];
    logic signed [23:0] wet_q [$];
    int                 errors = 0;
    bit                 calm = 1'b0;   // no idling on either side while set
    int                 hold_reqs = 0;

    // round half up after an arithmetic shift
    function automatic longint rnd(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // one biquad step of band b on the analysis (syn = 0) or synthesis history
    function automatic int biquad(bit syn, int b, int x);
        int     h [4];
        longint acc;
        int     y;
        for (int i = 0; i < 4; i++) h[i] = syn ? syn_hist[b*4+i] : ana_hist[b*4+i];
        acc = rnd(longint'(bq_b0[b]) * (longint'(x) - h[1]), 28)
            - rnd(longint'(bq_a1[b]) * h[2], 28)
            - rnd(longint'(bq_a2[b]) * h[3], 28);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        y = int'(acc);
        h[1] = h[0];
        h[0] = x;
        h[3] = h[2];
        h[2] = y;
        for (int i = 0; i < 4; i++) begin
            if (syn) syn_hist[b*4+i] = h[i];
            else ana_hist[b*4+i] = h[i];
        end
        return y;
    endfunction

    // averaged sawtooth oscillators; fixed mode slips its note in when none is held
    function automatic int saw_carrier();
        int sum;
        int n, s;
        longint unsigned p;
        logic [31:0] inc;
        sum = 0;
        if (!car_midi && n_held == 0) begin
            held[0] = fix_note;
            n_held = 1;
        end
        if (n_held == 0) return 0;
        for (int i = 0; i < n_held; i++) begin
            n = held[i];
            s = 34 - n / 12;
            p = OCT_HZ[n % 12] * longint'(inv_rate);
            inc = 32'((p + (64'd1 << (s - 1))) >> s);
            phase[i] = phase[i] + inc[23:0];
            sum += int'({8'd0, phase[i]}) - 8388608;
        end
        return sum / n_held;
    endfunction

    function automatic void vocode(t_vc_item it);
        int     modv, saw, nz, car, a, y2;
        longint mix, mag, c, wet, y;
        modv = int'((longint'(it.l) + longint'(it.r)) >>> 1);
        saw = saw_carrier();
        lcg = lcg * LCG_MUL + LCG_ADD;
        nz = int'({8'd0, lcg[31:8]}) - 8388608;
        mix = (nmix > 17'd65536) ? 65536 : longint'(nmix);
        car = int'(rnd(longint'(saw) * (65536 - mix) + longint'(nz) * mix, 16));
        wet = 0;
        for (int b = 0; b < NB; b++) begin
            a = biquad(1'b0, b, modv);
            mag = (a < 0) ? -longint'(a) : longint'(a);
            if (mag > 64'sd16777215) mag = 64'sd16777215;
            c = (mag > env_lvl[b]) ? longint'(atk) : longint'(rel);
            env_lvl[b] = int'((c * env_lvl[b] + (64'sd16777216 - c) * mag + 64'sd8388608) >>> 24);
            y2 = biquad(1'b1, b, car);
            wet += longint'(y2) * longint'(env_lvl[b]);
        end
        y = rnd(rnd(wet, 23) * longint'(gain), 22);
        if (y > 64'sd8388607) y = 64'sd8388607;
        if (y < -64'sd8388608) y = -64'sd8388608;
        wet_q.push_back(y[23:0]);
    endfunction

    function automatic void vocoder_step(t_vc_item it);
        bit dup;
        case (it.mode) inside
            MODE_SAMPLE: vocode(it);
            MODE_NOTE_ON: begin
                dup = 1'b0;
                for (int i = 0; i < n_held; i++) if (held[i] == it.note) dup = 1'b1;
                if (car_midi && !dup && n_held < NN) begin
                    held[n_held] = it.note;
                    phase[n_held] = '0;
                    n_held++;
                end
            end
            MODE_NOTE_OFF: begin
                for (int i = 0; i < n_held; i++) begin
                    if (held[i] == it.note) begin
                        // close the gap so the list stays packed
                        for (int j = i + 1; j < n_held; j++) begin
                            held[j-1] = held[j];
                            phase[j-1] = phase[j];
                        end
                        n_held--;
                        break;
                    end
                end
            end
            MODE_ALL_OFF, MODE_PANIC: begin
                n_held = 0;
                for (int i = 0; i < NB*4; i++) syn_hist[i] = 0;
                if (it.mode == MODE_PANIC) for (int b = 0; b < NB; b++) env_lvl[b] = 0;
            end
            MODE_LOAD: begin
                bq_b0[it.band] = it.b0;
                bq_a1[it.band] = it.a1;
                bq_a2[it.band] = it.a2;
            end
            default: ;
        endcase
    endfunction

    function automatic void cfg_apply(logic [2:0] idx, logic [31:0] d);
        case (idx)
            CFG_CARRIER_MODE: car_midi = d[0];
            CFG_FIXED_NOTE:   fix_note = d[6:0];
            CFG_ATTACK:       atk = d[23:0];
            CFG_RELEASE:      rel = d[23:0];
            CFG_GAIN:         gain = d[23:0];
            CFG_NOISE_MIX:    nmix = d[16:0];
            CFG_INV_RATE:     inv_rate = d;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // item builders; unused fields stay random so their bits toggle too
    // ---------------------------------------------------------------
    function automatic t_vc_item mk(logic [2:0] m);
        t_vc_item it;
        it.mode = m;
        it.l = 24'($urandom);
        it.r = 24'($urandom);
        it.note = 7'($urandom);
        it.band = 4'($urandom);
        it.b0 = $urandom;
        it.a1 = $urandom;
        it.a2 = $urandom;
        return it;
    endfunction

    // a band-pass that settles: a2 in about 0.8 .. 1, |a1| below 1 + a2
    function automatic t_vc_item mk_stable_load(int b);
        t_vc_item it;
        int       mag;
        it = mk(MODE_LOAD);
        it.band = b[3:0];
        it.a2 = $urandom_range(214748364, 268000000);
        mag = $urandom_range(0, 268435456 + it.a2 - 4000000);
        it.a1 = $urandom_range(0, 1) ? mag : -mag;
        it.b0 = $urandom_range(0, 1) ? $urandom_range(0, 30000000)
                                      : -$urandom_range(0, 30000000);
        return it;
    endfunction

    function automatic t_vc_item mk_note(logic [2:0] m);
        t_vc_item it;
        it = mk(m);
        // a small pool makes duplicates, removals and a full list common
        if ($urandom_range(0, 9) < 8) it.note = 7'($urandom_range(48, 59));
        return it;
    endfunction

    function automatic t_vc_item rand_item();
        int       pick;
        t_vc_item it;
        pick = $urandom_range(0, 99);
        if (pick < 68) it = mk(MODE_SAMPLE);
        else if (pick < 78) it = mk_note(MODE_NOTE_ON);
        else if (pick < 88) it = mk_note(MODE_NOTE_OFF);
        else if (pick < 90) it = mk(MODE_ALL_OFF);
        else if (pick < 92) it = mk(MODE_PANIC);
        else if (pick < 97) it = ($urandom_range(0, 9) < 8) ? mk_stable_load($urandom_range(0, 15))
                                                            : mk(MODE_LOAD);
        else it = mk(3'($urandom_range(6, 7)));
        return it;
    endfunction

    // ---------------------------------------------------------------
    // driver: one beat per queued item, random gap (none while calm) between items
    // ---------------------------------------------------------------
    t_vc_item cur;
    int       gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) vocoder_step(cur);
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    i_valid <= 1'b0;
                    gap_left--;
                end else if (item_q.size() > 0) begin
                    cur = item_q.pop_front();
                    i_mode <= cur.mode;
                    i_left_sample <= cur.l;
                    i_right_sample <= cur.r;
                    i_note <= cur.note;
                    i_band_index <= cur.band;
                    i_coef_b0 <= cur.b0;
                    i_coef_a1 <= cur.a1;
                    i_coef_a2 <= cur.a2;
                    i_valid <= 1'b1;
                    gap_left = calm ? 0 : $urandom_range(0, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // monitor: result beats against the oldest prediction
    // ---------------------------------------------------------------
    int rwait = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (wet_q.size() == 0) begin
                    $display("%0t unexpected wet_sample beat: expected none actual %0d",
                             $time, o_wet_sample);
                    errors++;
                end else if (o_wet_sample !== wet_q[0]) begin
                    $display("%0t wet_sample mismatch: expected %0d actual %0d",
                             $time, wet_q[0], o_wet_sample);
                    errors++;
                    void'(wet_q.pop_front());
                end else begin
                    void'(wet_q.pop_front());
                end
                rwait = calm ? 0 : $urandom_range(0, 6);
            end else if (rwait > 0) begin
                rwait--;
            end
            i_ready <= (rwait == 0) && (hold_left == 0);
        end
    end

    // run limit
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_apply(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    // sender stops until everything predicted has come out and the block has settled
    task automatic drain();
        @(posedge i_clk);
        while (item_q.size() > 0 || i_valid || wet_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_all(logic m, logic [6:0] fn, logic [23:0] at, logic [23:0] rl,
                           logic [23:0] g, logic [31:0] nm, logic [31:0] ir);
        cfg_write(CFG_CARRIER_MODE, {31'($urandom), m});
        cfg_write(CFG_FIXED_NOTE, {25'($urandom), fn});
        cfg_write(CFG_ATTACK, {8'($urandom), at});
        cfg_write(CFG_RELEASE, {8'($urandom), rl});
        cfg_write(CFG_GAIN, {8'($urandom), g});
        cfg_write(CFG_NOISE_MIX, nm);
        cfg_write(CFG_INV_RATE, ir);
    endtask

    initial begin
        t_vc_item it;
        // reset view of the predictor
        car_midi = 1'b0;
        fix_note = FIXED_NOTE_RST;
        atk = ATTACK_RST;
        rel = RELEASE_RST;
        gain = GAIN_RST;
        nmix = '0;
        inv_rate = INV_RATE_RST;
        for (int b = 0; b < NB; b++) begin
            bq_b0[b] = 0;
            bq_a1[b] = 0;
            bq_a2[b] = 0;
            env_lvl[b] = 0;
        end
        for (int i = 0; i < NB*4; i++) begin
            ana_hist[i] = 0;
            syn_hist[i] = 0;
        end
        for (int i = 0; i < NN; i++) begin
            held[i] = '0;
            phase[i] = '0;
        end
        n_held = 0;
        lcg = SEED_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every band loaded before any sample; band 15 gets extreme coefficients
        for (int b = 0; b < NB - 1; b++) item_q.push_back(mk_stable_load(b));
        it = mk(MODE_LOAD);
        it.band = 4'd15;
        it.b0 = 32'sh7FFFFFFF;
        it.a1 = 32'sh80000000;
        it.a2 = 32'sh7FFFFFFF;
        item_q.push_back(it);
        // full-scale modulator corners
        it = mk(MODE_SAMPLE); it.l = 24'sh7FFFFF; it.r = 24'sh7FFFFF; item_q.push_back(it);
        it = mk(MODE_SAMPLE); it.l = 24'sh800000; it.r = 24'sh800000; item_q.push_back(it);
        it = mk(MODE_SAMPLE); it.l = 24'sh7FFFFF; it.r = 24'sh800000; item_q.push_back(it);
        it = mk(MODE_SAMPLE); it.l = 24'sh000000; it.r = 24'shFFFFFF; item_q.push_back(it);
        // note on is ignored in fixed mode; note off still removes the fixed note
        it = mk(MODE_NOTE_ON); it.note = 7'd72; item_q.push_back(it);
        it = mk(MODE_NOTE_OFF); it.note = FIXED_NOTE_RST; item_q.push_back(it);
        item_q.push_back(mk(MODE_SAMPLE));
        item_q.push_back(mk(MODE_ALL_OFF));
        item_q.push_back(mk(MODE_SAMPLE));
        item_q.push_back(mk(MODE_PANIC));
        it = mk(3'd6); item_q.push_back(it);
        it = mk(3'd7); item_q.push_back(it);
        item_q.push_back(mk_stable_load(15));
        item_q.push_back(mk(MODE_SAMPLE));

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: cfg_all(1'b0, 7'd60, 24'd15728640, 24'd16609443, 24'd8388608, 32'd0,
                           32'd89478);
                1: cfg_all(1'b1, 7'd48, 24'($urandom), 24'($urandom_range(16000000, 16777215)),
                           24'($urandom), 32'd0, 32'($urandom_range(40000, 400000)));
                // extremes, fixed mode at the high note
                2: cfg_all(1'b0, 7'd84, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 32'h1FFFF,
                           32'hFFFFFFFF);
                // opposite extremes, midi mode with oscillators standing still
                3: cfg_all(1'b1, 7'd36, 24'hFFFFFF, 24'd0, 24'd0, 32'd65536, 32'd0);
                4: cfg_all(1'b0, 7'($urandom_range(36, 84)), 24'($urandom), 24'($urandom),
                           24'($urandom), 32'($urandom_range(0, 65536)), $urandom);
                default: cfg_all(1'($urandom_range(0, 1)), 7'($urandom), 24'($urandom),
                                 24'($urandom), 24'($urandom), $urandom, $urandom);
            endcase
            calm = (ph == 4);
            for (int k = 0; k < 205; k++) item_q.push_back(rand_item());
            // receiver holds off long enough for the block to stall its input
            if (ph == 1) hold_reqs++;
        end

        drain();
        if (wet_q.size() > 0) begin
            $display("%0t %0d wet_sample beats missing: expected %0d actual none",
                     $time, wet_q.size(), wet_q[0]);
            errors++;
        end
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
